[rtl/core/pbra_pkg.sv]
package pbra_pkg;

    localparam int AXIS_W = 21;

    typedef enum logic [1:0] {
        KIND_CLEAR = 2'd0,
        KIND_ADD   = 2'd1
    } t_kind_unused;

    typedef enum logic [2:0] {
        REG_ORIGIN_X  = 3'd0,
        REG_ORIGIN_Y  = 3'd1,
        REG_ORIGIN_Z  = 3'd2,
        REG_EYE_DIR   = 3'd3,
        REG_RIGHT     = 3'd4,
        REG_UP        = 3'd5,
        REG_EYE_DIST  = 3'd6,
        REG_PERSP     = 3'd7
    } t_reg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_OFFSET,
        ST_DMUL,
        ST_DACC,
        ST_CHECK,
        ST_DIV,
        ST_EMUL1,
        ST_EACC1,
        ST_EMUL2,
        ST_EACC2,
        ST_XMUL,
        ST_XACC,
        ST_YMUL,
        ST_YACC,
        ST_EXMUL,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic [62:0]        eye_dir;
        logic [62:0]        right_axis;
        logic [62:0]        up_axis;
        logic [31:0]        eye_dist;
        logic               persp;
    } t_cfg;

    typedef struct packed {
        logic               add;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] ext_top;
        logic signed [31:0] ext_bottom;
        logic signed [31:0] ext_left;
        logic signed [31:0] ext_right;
    } t_item;

    typedef struct packed {
        logic signed [31:0] top;
        logic signed [31:0] bottom;
        logic signed [31:0] left;
        logic signed [31:0] right;
        logic               rect_valid;
        logic               skipped;
    } t_result;

    localparam logic signed [71:0] SAT_MAX = 72'sd2147483647;
    localparam logic signed [71:0] SAT_MIN = -72'sd2147483648;

    function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
        logic signed [31:0] r;
        if (v > SAT_MAX) begin
            r = 32'sh7fffffff;
        end else if (v < SAT_MIN) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [20:0] axis_comp(input logic [62:0] p,
                                                    input logic [1:0] i);
        logic signed [20:0] r;
        case (i)
            2'd0:    r = p[20:0];
            2'd1:    r = p[41:21];
            default: r = p[62:42];
        endcase
        return r;
    endfunction

endpackage

[rtl/core/pbra_front.sv]
module pbra_front
    import pbra_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    output logic  o_full,
    input  t_item i_item,
    output logic  o_avail,
    output t_item o_item,
    input  logic  i_take
);

    // two-entry request queue between the ports and the sequencer
    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       wr;
    logic       rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_avail = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];
    assign wr      = i_push && !o_full;
    assign rd      = i_take && o_avail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) begin
                r_wp <= !r_wp;
            end
            if (rd) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(wr) - 2'(rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

[rtl/core/pbra_back.sv]
module pbra_back
    import pbra_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_avail,
    input  t_item   i_item,
    output logic    o_take,
    output logic    o_res_valid,
    output t_result o_res,
    input  logic    i_res_ready
);

    t_state r_state;
    t_state n_state;

    t_item              r_item;
    logic [1:0]         r_idx;
    logic [4:0]         r_cnt;
    logic signed [32:0] r_o [3];
    logic signed [31:0] r_e [3];
    logic signed [31:0] r_ext [4];
    logic signed [55:0] r_depth;
    logic signed [55:0] r_sx;
    logic signed [55:0] r_sy;
    logic signed [49:0] r_m1;
    logic signed [68:0] r_prod;
    logic [56:0]        r_rem;
    logic [31:0]        r_scale;
    logic               r_skip;
    logic signed [31:0] r_top;
    logic signed [31:0] r_bottom;
    logic signed [31:0] r_left;
    logic signed [31:0] r_right;

    logic signed [35:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [32:0] o_cur;
    logic [32:0]        o_mag;
    logic signed [31:0] ext_cur;
    logic [31:0]        ext_mag;
    logic signed [20:0] ev_cur;
    logic [56:0]        den;
    logic [56:0]        rem2;
    logic               depth_le0;
    logic               sat_scale;
    logic signed [49:0] scaled_o;
    logic signed [31:0] e_next;
    logic signed [31:0] ext_next;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] t_new;
    logic signed [31:0] b_new;
    logic signed [31:0] l_new;
    logic signed [31:0] r_new;

    assign o_cur   = r_o[r_idx];
    assign o_mag   = o_cur[32] ? 33'(-o_cur) : 33'(o_cur);
    assign ext_cur = r_ext[r_idx];
    assign ext_mag = ext_cur[31] ? 32'(-ext_cur) : 32'(ext_cur);
    assign ev_cur  = axis_comp(i_cfg.eye_dir, r_idx);
    assign den     = {1'b0, r_depth};
    assign rem2    = {r_rem[55:0], 1'b0};
    assign depth_le0 = (r_depth <= 56'sd0);
    assign sat_scale = {22'd0, i_cfg.eye_dist, 3'b000} >= den;

    // scale_mul for the current offset component, truncated toward zero
    assign scaled_o = o_cur[32] ? -50'(r_prod[68:16]) : 50'(r_prod[68:16]);
    assign ext_next = r_ext[r_idx][31] ? sat32(-72'(r_prod[68:16]))
                                       : sat32(72'(r_prod[68:16]));
    assign e_next = i_cfg.persp ? sat32(72'(r_m1) - 72'(r_prod >>> 19))
                                : sat32(72'(o_cur) - 72'(r_prod >>> 19));

    // shared multiplier operand selection
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_DMUL: begin
                mul_a = 36'(o_cur);
                mul_b = 33'(ev_cur);
            end
            ST_EMUL1: begin
                if (i_cfg.persp) begin
                    mul_a = {3'b000, o_mag};
                    mul_b = {1'b0, r_scale};
                end else begin
                    mul_a = 36'(r_depth >>> 19);
                    mul_b = 33'(ev_cur);
                end
            end
            ST_EMUL2: begin
                mul_a = {4'b0000, i_cfg.eye_dist};
                mul_b = 33'(ev_cur);
            end
            ST_XMUL: begin
                mul_a = 36'(r_e[r_idx]);
                mul_b = 33'(axis_comp(i_cfg.right_axis, r_idx));
            end
            ST_YMUL: begin
                mul_a = 36'(r_e[r_idx]);
                mul_b = 33'(axis_comp(i_cfg.up_axis, r_idx));
            end
            ST_EXMUL: begin
                mul_a = {4'b0000, ext_mag};
                mul_b = {1'b0, r_scale};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // final projection, extents and bound update
    assign px    = sat32(72'(r_sx >>> 19));
    assign py    = sat32(72'(r_sy >>> 19));
    always_comb begin
        t_new = sat32(72'(py) + 72'(r_ext[0]));
        b_new = sat32(72'(py) + 72'(r_ext[1]));
        l_new = sat32(72'(px) + 72'(r_ext[2]));
        r_new = sat32(72'(px) + 72'(r_ext[3]));
        o_res.skipped = r_skip;
        if (!r_item.add) begin
            o_res.top    = 32'sh80000000;
            o_res.bottom = 32'sh7fffffff;
            o_res.left   = 32'sh7fffffff;
            o_res.right  = 32'sh80000000;
        end else if (r_skip) begin
            o_res.top    = r_top;
            o_res.bottom = r_bottom;
            o_res.left   = r_left;
            o_res.right  = r_right;
        end else begin
            o_res.top    = (t_new > r_top) ? t_new : r_top;
            o_res.bottom = (b_new < r_bottom) ? b_new : r_bottom;
            o_res.left   = (l_new < r_left) ? l_new : r_left;
            o_res.right  = (r_new > r_right) ? r_new : r_right;
        end
        o_res.rect_valid = (o_res.top > o_res.bottom) && (o_res.right > o_res.left);
    end

    assign o_take      = (r_state == ST_IDLE) && i_avail;
    assign o_res_valid = (r_state == ST_FINISH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (i_avail) n_state = i_item.add ? ST_OFFSET : ST_FINISH;
            ST_OFFSET: n_state = ST_DMUL;
            ST_DMUL:   n_state = ST_DACC;
            ST_DACC:   n_state = (r_idx == 2'd2) ? ST_CHECK : ST_DMUL;
            ST_CHECK: begin
                if (i_cfg.persp && depth_le0) begin
                    n_state = ST_FINISH;
                end else if (i_cfg.persp && !sat_scale) begin
                    n_state = ST_DIV;
                end else begin
                    n_state = ST_EMUL1;
                end
            end
            ST_DIV:    if (r_cnt == 5'd31) n_state = ST_EMUL1;
            ST_EMUL1:  n_state = ST_EACC1;
            ST_EACC1: begin
                if (i_cfg.persp) begin
                    n_state = ST_EMUL2;
                end else begin
                    n_state = (r_idx == 2'd2) ? ST_XMUL : ST_EMUL1;
                end
            end
            ST_EMUL2:  n_state = ST_EACC2;
            ST_EACC2:  n_state = (r_idx == 2'd2) ? ST_XMUL : ST_EMUL1;
            ST_XMUL:   n_state = ST_XACC;
            ST_XACC:   n_state = ST_YMUL;
            ST_YMUL:   n_state = ST_YACC;
            ST_YACC: begin
                if (r_idx != 2'd2) begin
                    n_state = ST_XMUL;
                end else begin
                    n_state = i_cfg.persp ? ST_EXMUL : ST_FINISH;
                end
            end
            ST_EXMUL:  n_state = ST_FINISH;
            ST_FINISH: if (i_res_ready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
        // extent scaling loops through EXMUL with a product wait in FINISH-free form
        if (r_state == ST_EXMUL) begin
            n_state = ST_EXMUL;
            if (r_cnt == 5'd8) n_state = ST_FINISH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top    <= 32'sh80000000;
            r_bottom <= 32'sh7fffffff;
            r_left   <= 32'sh7fffffff;
            r_right  <= 32'sh80000000;
        end else if (r_state == ST_FINISH && i_res_ready) begin
            r_top    <= o_res.top;
            r_bottom <= o_res.bottom;
            r_left   <= o_res.left;
            r_right  <= o_res.right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        case (r_state)
            ST_IDLE: begin
                r_item <= i_item;
                r_skip <= 1'b0;
            end
            ST_OFFSET: begin
                r_o[0]  <= 33'(r_item.pos_x) - 33'(i_cfg.origin_x);
                r_o[1]  <= 33'(r_item.pos_y) - 33'(i_cfg.origin_y);
                r_o[2]  <= 33'(r_item.pos_z) - 33'(i_cfg.origin_z);
                r_ext[0] <= r_item.ext_top;
                r_ext[1] <= r_item.ext_bottom;
                r_ext[2] <= r_item.ext_left;
                r_ext[3] <= r_item.ext_right;
                r_idx   <= 2'd0;
                r_depth <= '0;
                r_sx    <= '0;
                r_sy    <= '0;
            end
            ST_DACC: begin
                r_depth <= r_depth + 56'(r_prod);
                r_idx   <= (r_idx == 2'd2) ? 2'd0 : r_idx + 2'd1;
            end
            ST_CHECK: begin
                r_skip  <= i_cfg.persp && depth_le0;
                r_scale <= 32'hffffffff;
                r_rem   <= {22'd0, i_cfg.eye_dist, 3'b000};
                r_cnt   <= 5'd0;
            end
            ST_DIV: begin
                // restoring division, one quotient bit a cycle
                if (rem2 >= den) begin
                    r_rem <= rem2 - den;
                end else begin
                    r_rem <= rem2;
                end
                // first bit drops the saturation preset
                r_scale <= (r_cnt == 5'd0) ? {31'd0, rem2 >= den}
                                           : {r_scale[30:0], rem2 >= den};
                r_cnt <= r_cnt + 5'd1;
            end
            ST_EACC1: begin
                if (i_cfg.persp) begin
                    r_m1 <= scaled_o;
                end else begin
                    r_e[r_idx] <= e_next;
                    r_idx      <= (r_idx == 2'd2) ? 2'd0 : r_idx + 2'd1;
                end
            end
            ST_EACC2: begin
                r_e[r_idx] <= e_next;
                r_idx      <= (r_idx == 2'd2) ? 2'd0 : r_idx + 2'd1;
            end
            ST_XACC: r_sx <= r_sx + 56'(r_prod);
            ST_YACC: begin
                r_sy  <= r_sy + 56'(r_prod);
                r_idx <= (r_idx == 2'd2) ? 2'd0 : r_idx + 2'd1;
                r_cnt <= 5'd0;
            end
            ST_EXMUL: begin
                // even counts issue a product, odd counts write the extent back
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt[0]) begin
                    r_ext[r_idx] <= ext_next;
                    r_idx        <= r_idx + 2'd1;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

[rtl/core/projected_bounding_rect_accumulator_unit.sv]
// request paths: a clear, an orthographic add, a perspective add behind the eye,
//   a perspective add with a saturated scale, and any other perspective add, which also
//   runs the bit-serial scale divider
// sequencing: one request at a time through the sequencer and its shared 36x33 multiplier,
//   so the next request waits for the last to finish; a two-entry queue and a result register decouple the ports
// reset: synchronous active-low; empties queue and result register, bounds go to
//   the empty rectangle and configuration to its defaults (eye distance 1.0)
module projected_bounding_rect_accumulator_unit
    import pbra_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request side
    input  logic               push,
    output logic               full,
    input  logic               i_kind,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [31:0] i_ext_top,
    input  logic signed [31:0] i_ext_bottom,
    input  logic signed [31:0] i_ext_left,
    input  logic signed [31:0] i_ext_right,
    // result side
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] o_bound_top,
    output logic signed [31:0] o_bound_bottom,
    output logic signed [31:0] o_bound_left,
    output logic signed [31:0] o_bound_right,
    output logic               o_rect_valid,
    output logic               o_item_skipped,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);

    t_cfg    r_cfg;
    t_item   in_item;
    t_item   q_item;
    logic    q_avail;
    logic    q_take;
    t_result res;
    logic    res_valid;
    logic    res_ready;
    t_result r_out;
    logic    r_out_valid;
    logic    cfg_wr;
    t_reg    reg_sel;

    // registers sit on 8-byte boundaries since the axis words are 63 bits
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = t_reg'(paddr[5:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x   <= '0;
            r_cfg.origin_y   <= '0;
            r_cfg.origin_z   <= '0;
            r_cfg.eye_dir    <= '0;
            r_cfg.right_axis <= '0;
            r_cfg.up_axis    <= '0;
            r_cfg.eye_dist   <= 32'h0001_0000;
            r_cfg.persp      <= 1'b0;
        end else if (cfg_wr) begin
            case (reg_sel)
                REG_ORIGIN_X: r_cfg.origin_x   <= pwdata[31:0];
                REG_ORIGIN_Y: r_cfg.origin_y   <= pwdata[31:0];
                REG_ORIGIN_Z: r_cfg.origin_z   <= pwdata[31:0];
                REG_EYE_DIR:  r_cfg.eye_dir    <= pwdata[62:0];
                REG_RIGHT:    r_cfg.right_axis <= pwdata[62:0];
                REG_UP:       r_cfg.up_axis    <= pwdata[62:0];
                REG_EYE_DIST: r_cfg.eye_dist   <= pwdata[31:0];
                REG_PERSP:    r_cfg.persp      <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    // read-back mux
    always_comb begin
        case (reg_sel)
            REG_ORIGIN_X: prdata = 64'(unsigned'(r_cfg.origin_x));
            REG_ORIGIN_Y: prdata = 64'(unsigned'(r_cfg.origin_y));
            REG_ORIGIN_Z: prdata = 64'(unsigned'(r_cfg.origin_z));
            REG_EYE_DIR:  prdata = {1'b0, r_cfg.eye_dir};
            REG_RIGHT:    prdata = {1'b0, r_cfg.right_axis};
            REG_UP:       prdata = {1'b0, r_cfg.up_axis};
            REG_EYE_DIST: prdata = {32'd0, r_cfg.eye_dist};
            REG_PERSP:    prdata = {63'd0, r_cfg.persp};
            default:      prdata = '0;
        endcase
    end

    assign in_item.add        = i_kind;
    assign in_item.pos_x      = i_pos_x;
    assign in_item.pos_y      = i_pos_y;
    assign in_item.pos_z      = i_pos_z;
    assign in_item.ext_top    = i_ext_top;
    assign in_item.ext_bottom = i_ext_bottom;
    assign in_item.ext_left   = i_ext_left;
    assign in_item.ext_right  = i_ext_right;

    // front: request queue
    pbra_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_item  (in_item),
        .o_avail (q_avail),
        .o_item  (q_item),
        .i_take  (q_take)
    );

    // back: projection sequencer and running bounds
    pbra_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_avail     (q_avail),
        .i_item      (q_item),
        .o_take      (q_take),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    // result register; refills in the cycle it is popped
    assign res_ready = !r_out_valid || pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign empty          = !r_out_valid;
    assign o_bound_top    = r_out.top;
    assign o_bound_bottom = r_out.bottom;
    assign o_bound_left   = r_out.left;
    assign o_bound_right  = r_out.right;
    assign o_rect_valid   = r_out.rect_valid;
    assign o_item_skipped = r_out.skipped;

    // queue and result register come up empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queue or result register not empty after reset");

    // a finished result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && res_ready && r_out_valid) |-> pop)
        else $error("result overwritten before pop");

    // a held result stays put until popped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> ($stable(o_bound_top) && $stable(o_bound_right)))
        else $error("waiting result changed");

    // only perspective mode skips items
    a_skip_persp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_item_skipped) |-> r_cfg.persp)
        else $error("skip flagged in orthographic mode");

endmodule
